### src/obstacle_track_association_defines.svh
// ----------------------------------------------------------------------------
// Obstacle track association assertion macros
// Shared clocking and reporting form for the block's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef OBSTACLE_TRACK_ASSOCIATION_DEFINES_SVH
`define OBSTACLE_TRACK_ASSOCIATION_DEFINES_SVH

// labeled concurrent check, clocked on clk_i and off during reset
`define OTA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// labeled check that cons holds in the cycle after ante
`define OTA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

### src/ota_pkg.sv
// ----------------------------------------------------------------------------
// Obstacle track association package
// Shared constants, slot record type and controller states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ota_pkg;

  localparam int unsigned TRACK_SLOTS_DEF = 64;
  localparam int unsigned COORD_W         = 16;
  localparam int unsigned SUM_W           = 32;
  localparam int unsigned DIV_STEPS       = 32;

  localparam logic [15:0] COUNT_MAX   = 16'hFFFF;
  localparam logic [15:0] ID_MAX      = 16'hFFFF;
  localparam logic [15:0] RADIUS_RST  = 16'd300;
  localparam logic [15:0] CONFIRM_RST = 16'd3;

  // register select (byte address bit 2)
  localparam logic REG_RADIUS  = 1'b0;
  localparam logic REG_CONFIRM = 1'b1;

  typedef struct packed {
    logic              valid;
    logic [15:0]       id;
    logic [15:0]       count;
    logic [SUM_W-1:0]  sum_x;
    logic [SUM_W-1:0]  sum_y;
    logic [SUM_W-1:0]  sum_z;
    logic [COORD_W-1:0] mean_x;
    logic [COORD_W-1:0] mean_y;
  } slot_rec_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DECIDE,
    ST_DIV
  } state_e;

endpackage

### src/ota_cell.sv
// ----------------------------------------------------------------------------
// Track slot cell
// Holds one slot record; shifts to its ring neighbor or takes a write-back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ota_cell import ota_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      shift_i,
  input  slot_rec_t rec_i,
  input  logic      wr_i,
  input  slot_rec_t wr_rec_i,
  output slot_rec_t rec_o
);

  logic      valid_q;
  slot_rec_t data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (wr_i) begin
      valid_q <= wr_rec_i.valid;
    end else if (shift_i) begin
      valid_q <= rec_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      data_q <= wr_rec_i;
    end else if (shift_i) begin
      data_q <= rec_i;
    end
  end

  always_comb begin
    rec_o       = data_q;
    rec_o.valid = valid_q;
  end

endmodule

### src/ota_div.sv
// ----------------------------------------------------------------------------
// Serial mean divider
// Signed sum over unsigned count, truncated, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ota_div import ota_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [SUM_W-1:0]   dividend_i,
  input  logic [15:0]        divisor_i,
  output logic               done_o,
  output logic [COORD_W-1:0] quot_o
);

  localparam int unsigned STEP_W = $clog2(DIV_STEPS);

  logic              run_q, done_q, neg_q;
  logic [STEP_W-1:0] step_q;
  logic [15:0]       d_q;
  logic [SUM_W-1:0]  q_q;
  logic [15:0]       r_q;
  logic [16:0]       rem_sh;
  logic              ge;
  logic [SUM_W-1:0]  qneg;

  assign rem_sh = {r_q, q_q[SUM_W-1]};
  assign ge     = rem_sh >= {1'b0, d_q};
  assign qneg   = SUM_W'(0) - q_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= '0;
      end else if (run_q) begin
        step_q <= step_q + STEP_W'(1);
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[SUM_W-1];
      q_q   <= dividend_i[SUM_W-1] ? (SUM_W'(0) - dividend_i) : dividend_i;
      d_q   <= divisor_i;
      r_q   <= '0;
    end else if (run_q) begin
      r_q <= ge ? 16'(rem_sh - {1'b0, d_q}) : rem_sh[15:0];
      q_q <= {q_q[SUM_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? qneg[COORD_W-1:0] : q_q[COORD_W-1:0];

endmodule

### src/obstacle_track_association.sv
// ----------------------------------------------------------------------------
// Obstacle track association
// Gates each centroid against a slot ring; updates one track unless full.
// ----------------------------------------------------------------------------
// One centroid word is taken per start pulse while busy is low; its result
// word appears on the result ports for exactly one cycle, flagged by
// result_valid_o, and there is no way to hold it off, so capture it on that
// cycle. An item first walks the slot ring, which rotates every slot past the
// gate test, then drains the gate pipeline; when a track is matched or opened,
// the 32-step serial dividers then form the new track mean, and when the
// table is full the item ends there. busy stays high over the whole walk.
`timescale 1ns / 1ps
`include "obstacle_track_association_defines.svh"

module obstacle_track_association import ota_pkg::*; #(
  parameter int unsigned TRACK_SLOTS = TRACK_SLOTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // centroid command
  input  logic               start,
  output logic               busy,
  input  logic [COORD_W-1:0] pos_x_i,
  input  logic [COORD_W-1:0] pos_y_i,
  input  logic [COORD_W-1:0] pos_z_i,
  // result word
  output logic               result_valid_o,
  output logic [15:0]        track_id_o,
  output logic [15:0]        update_count_o,
  output logic [COORD_W-1:0] mean_x_o,
  output logic [COORD_W-1:0] mean_y_o,
  output logic [COORD_W-1:0] mean_z_o,
  output logic               confirmed_o,
  output logic               table_full_o,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned IDX_W = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;
  localparam int unsigned POS_W = $clog2(TRACK_SLOTS + 1);

  // --------------------------------------------------------------------------
  // Registers: gate radius and confirmation threshold
  // --------------------------------------------------------------------------
  logic [15:0] radius_q, confirm_q;
  logic        cfg_wr;

  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CONFIRM) ? {16'd0, confirm_q} : {16'd0, radius_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q  <= RADIUS_RST;
      confirm_q <= CONFIRM_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_CONFIRM) begin
        confirm_q <= pwdata[15:0];
      end else begin
        radius_q <= pwdata[15:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Slot ring: cell i takes cell i+1, cell 0 is the head under test. After
  // TRACK_SLOTS shifts every record is back in its home cell, so the head
  // shows slots in ascending order and write-back uses the home index.
  // --------------------------------------------------------------------------
  slot_rec_t            ring [TRACK_SLOTS];
  logic                 shift, wr_en;
  slot_rec_t            wr_rec;
  logic [IDX_W-1:0]     tgt_idx_q;

  for (genvar i = 0; i < TRACK_SLOTS; i++) begin : g_cell
    ota_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (shift),
      .rec_i    (ring[(i + 1) % TRACK_SLOTS]),
      .wr_i     (wr_en && (tgt_idx_q == IDX_W'(i))),
      .wr_rec_i (wr_rec),
      .rec_o    (ring[i])
    );
  end

  // --------------------------------------------------------------------------
  // Controller
  // --------------------------------------------------------------------------
  state_e           state_q, state_d;
  logic [POS_W-1:0] pos_q;
  logic             load_in, div_start, res_full, div_done;
  logic             hit_f_q, free_f_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    load_in   = 1'b0;
    shift     = 1'b0;
    div_start = 1'b0;
    res_full  = 1'b0;
    wr_en     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          load_in = 1'b1;
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        shift = pos_q < POS_W'(TRACK_SLOTS);
        if (pos_q == POS_W'(TRACK_SLOTS)) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (hit_f_q || free_f_q) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end else begin
          res_full = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          wr_en   = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (load_in) begin
      pos_q <= '0;
    end else if (state_q == ST_WALK) begin
      pos_q <= pos_q + POS_W'(1);
    end
  end

  // --------------------------------------------------------------------------
  // Gate pipeline: stage 1 squares the x-y offsets to the head's mean,
  // stage 2 sums, compares against radius squared and keeps first hit/free.
  // --------------------------------------------------------------------------
  logic signed [COORD_W-1:0] px_q, py_q, pz_q;
  logic [31:0]               r2_q;
  logic signed [16:0]        dx, dy;
  logic signed [33:0]        sqx, sqy;

  always_ff @(posedge clk_i) begin
    if (load_in) begin
      px_q <= pos_x_i;
      py_q <= pos_y_i;
      pz_q <= pos_z_i;
      r2_q <= radius_q * radius_q;
    end
  end

  assign dx  = $signed({px_q[COORD_W-1], px_q}) -
               $signed({ring[0].mean_x[COORD_W-1], ring[0].mean_x});
  assign dy  = $signed({py_q[COORD_W-1], py_q}) -
               $signed({ring[0].mean_y[COORD_W-1], ring[0].mean_y});
  assign sqx = dx * dx;
  assign sqy = dy * dy;

  logic             s1_v_q;
  logic [IDX_W-1:0] s1_idx_q;
  slot_rec_t        s1_rec_q;
  logic [31:0]      s1_dx2_q, s1_dy2_q;
  logic [32:0]      d2;
  logic             in_gate;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= shift;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift) begin
      s1_idx_q <= pos_q[IDX_W-1:0];
      s1_rec_q <= ring[0];
      s1_dx2_q <= sqx[31:0];
      s1_dy2_q <= sqy[31:0];
    end
  end

  assign d2      = {1'b0, s1_dx2_q} + {1'b0, s1_dy2_q};
  assign in_gate = d2 < {1'b0, r2_q};

  logic [IDX_W-1:0] hit_idx_q, free_idx_q;
  slot_rec_t        hit_rec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_f_q  <= 1'b0;
      free_f_q <= 1'b0;
    end else if (load_in) begin
      hit_f_q  <= 1'b0;
      free_f_q <= 1'b0;
    end else if (s1_v_q) begin
      if (!s1_rec_q.valid && !free_f_q) begin
        free_f_q <= 1'b1;
      end
      if (s1_rec_q.valid && in_gate && !hit_f_q) begin
        hit_f_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      if (!s1_rec_q.valid && !free_f_q) begin
        free_idx_q <= s1_idx_q;
      end
      if (s1_rec_q.valid && in_gate && !hit_f_q) begin
        hit_idx_q <= s1_idx_q;
        hit_rec_q <= s1_rec_q;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Update: matched track accumulates unless saturated, else a new track
  // opens with the next id (wraps past the top back to 1, never 0).
  // --------------------------------------------------------------------------
  logic [15:0]      last_id_q, new_id;
  slot_rec_t        upd_d, upd_rec_q;
  logic [SUM_W-1:0] ext_x, ext_y, ext_z;

  assign new_id = (last_id_q == ID_MAX) ? 16'd1 : last_id_q + 16'd1;
  assign ext_x  = {{(SUM_W-COORD_W){px_q[COORD_W-1]}}, px_q};
  assign ext_y  = {{(SUM_W-COORD_W){py_q[COORD_W-1]}}, py_q};
  assign ext_z  = {{(SUM_W-COORD_W){pz_q[COORD_W-1]}}, pz_q};

  always_comb begin
    upd_d = hit_rec_q;
    if (hit_f_q) begin
      if (hit_rec_q.count != COUNT_MAX) begin
        upd_d.count = hit_rec_q.count + 16'd1;
        upd_d.sum_x = hit_rec_q.sum_x + ext_x;
        upd_d.sum_y = hit_rec_q.sum_y + ext_y;
        upd_d.sum_z = hit_rec_q.sum_z + ext_z;
      end
    end else begin
      upd_d.valid = 1'b1;
      upd_d.id    = new_id;
      upd_d.count = 16'd1;
      upd_d.sum_x = ext_x;
      upd_d.sum_y = ext_y;
      upd_d.sum_z = ext_z;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_id_q <= '0;
    end else if (div_start && !hit_f_q) begin
      last_id_q <= new_id;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      upd_rec_q <= upd_d;
      tgt_idx_q <= hit_f_q ? hit_idx_q : free_idx_q;
    end
  end

  // --------------------------------------------------------------------------
  // Mean dividers, one per axis, started together
  // --------------------------------------------------------------------------
  logic [COORD_W-1:0] qx, qy, qz;
  logic               done_y, done_z;

  ota_div u_div_x (
    .clk_i, .rst_ni, .start_i (div_start), .dividend_i (upd_d.sum_x),
    .divisor_i (upd_d.count), .done_o (div_done), .quot_o (qx)
  );
  ota_div u_div_y (
    .clk_i, .rst_ni, .start_i (div_start), .dividend_i (upd_d.sum_y),
    .divisor_i (upd_d.count), .done_o (done_y), .quot_o (qy)
  );
  ota_div u_div_z (
    .clk_i, .rst_ni, .start_i (div_start), .dividend_i (upd_d.sum_z),
    .divisor_i (upd_d.count), .done_o (done_z), .quot_o (qz)
  );

  always_comb begin
    wr_rec        = upd_rec_q;
    wr_rec.mean_x = qx;
    wr_rec.mean_y = qy;
  end

  // --------------------------------------------------------------------------
  // Result word
  // --------------------------------------------------------------------------
  logic res_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q <= 1'b0;
    end else begin
      res_v_q <= wr_en | res_full;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_full) begin
      track_id_o     <= '0;
      update_count_o <= '0;
      mean_x_o       <= '0;
      mean_y_o       <= '0;
      mean_z_o       <= '0;
      confirmed_o    <= 1'b0;
      table_full_o   <= 1'b1;
    end else if (wr_en) begin
      track_id_o     <= upd_rec_q.id;
      update_count_o <= upd_rec_q.count;
      mean_x_o       <= qx;
      mean_y_o       <= qy;
      mean_z_o       <= qz;
      confirmed_o    <= upd_rec_q.count >= confirm_q;
      table_full_o   <= 1'b0;
    end
  end

  assign result_valid_o = res_v_q;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  `OTA_ASSERT_NEXT(a_one_word, result_valid_o, !result_valid_o, "back-to-back result words")
  `OTA_ASSERT(a_full_id, result_valid_o && table_full_o |-> track_id_o == 16'd0,
              "full table result carries an id")
  `OTA_ASSERT(a_live_id, result_valid_o && !table_full_o |-> track_id_o != 16'd0,
              "stored track reported with id zero")
  `OTA_ASSERT_NEXT(a_take_busy, start && !busy, busy, "accepted centroid did not raise busy")
  `OTA_ASSERT(a_div_sync, div_done == done_y && div_done == done_z, "dividers out of step")

endmodule
